### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold on a rising clock edge outside reset
`define PPT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/ppt_pkg.sv
// package: shared constants, register indexes and flag struct
package ppt_pkg;

  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 16;
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  typedef enum logic [2:0] {
    REG_PAIR_0_1 = 3'd0,
    REG_PAIR_2_3 = 3'd1,
    REG_PAIR_4_5 = 3'd2,
    REG_PAIR_6_7 = 3'd3,
    REG_LAST     = 3'd4,
    REG_MODE     = 3'd5
  } ppt_reg_e;

  // per-item status flowing down the divider row
  typedef struct packed {
    logic xn;   // x numerator negative
    logic yn;   // y numerator negative
    logic dn;   // denominator negative
    logic dz;   // denominator zero
    logic xo;   // x quotient too large for the cell row
    logic yo;   // y quotient too large for the cell row
  } ppt_flags_t;

endpackage

### rtl/core/ppt_mac.sv
// two-stage front end: six products, then three sums with sign and magnitude
module ppt_mac import ppt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [COORD_BITS-1:0]       x_i,
  input  logic signed [COORD_BITS-1:0]       y_i,
  input  logic signed [COEF_BITS-1:0]        cx_i [3],
  input  logic signed [COEF_BITS-1:0]        cy_i [3],
  input  logic signed [COEF_BITS-1:0]        cc_i [3],
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [COORD_BITS+33:0]             xm_o,
  output logic [COORD_BITS+33:0]             ym_o,
  output logic [COORD_BITS+33:0]             dm_o,
  output ppt_flags_t                         flags_o
);
  localparam int PW = COORD_BITS + COEF_BITS;
  localparam int SW = COORD_BITS + 34;
  localparam int QB = COORD_BITS + 1;

  logic                 v1_q, v2_q, rdy2;
  logic signed [PW-1:0] px_q [3];
  logic signed [PW-1:0] py_q [3];
  logic signed [COEF_BITS-1:0] pc_q [3];
  logic signed [SW-1:0] s [3];
  logic [SW-1:0]        m [3];
  logic [SW-1:0]        m_q [3];
  ppt_flags_t           f_d, f_q;

  assign rdy2    = !v2_q || ready_i;
  assign ready_o = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready_o) v1_q <= valid_i;
      if (rdy2)    v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= PW'(x_i) * PW'(cx_i[i]);
        py_q[i] <= PW'(y_i) * PW'(cy_i[i]);
        pc_q[i] <= cc_i[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = SW'(px_q[i]) + SW'(py_q[i]) + SW'(pc_q[i]);
      m[i] = s[i][SW-1] ? (~s[i] + SW'(1)) : s[i];
    end
    f_d.xn = s[0][SW-1];
    f_d.yn = s[1][SW-1];
    f_d.dn = s[2][SW-1];
    f_d.dz = (m[2] == '0);
    f_d.xo = {{QB{1'b0}}, m[0]} >= {m[2], {QB{1'b0}}};
    f_d.yo = {{QB{1'b0}}, m[1]} >= {m[2], {QB{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int i = 0; i < 3; i++) m_q[i] <= m[i];
      f_q <= f_d;
    end
  end

  assign valid_o = v2_q;
  assign xm_o    = m_q[0];
  assign ym_o    = m_q[1];
  assign dm_o    = m_q[2];
  assign flags_o = f_q;
endmodule

### rtl/core/ppt_div_cell.sv
// one restoring division cell: settles quotient bit BIT for x and y
module ppt_div_cell import ppt_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int BIT        = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [COORD_BITS+33:0]  rx_i,
  input  logic [COORD_BITS+33:0]  ry_i,
  input  logic [COORD_BITS+33:0]  dm_i,
  input  logic [COORD_BITS:0]     qx_i,
  input  logic [COORD_BITS:0]     qy_i,
  input  ppt_flags_t              flags_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [COORD_BITS+33:0]  rx_o,
  output logic [COORD_BITS+33:0]  ry_o,
  output logic [COORD_BITS+33:0]  dm_o,
  output logic [COORD_BITS:0]     qx_o,
  output logic [COORD_BITS:0]     qy_o,
  output ppt_flags_t              flags_o
);
  localparam int SW = COORD_BITS + 34;
  localparam int QB = COORD_BITS + 1;

  logic              v_q;
  logic [SW+QB-1:0]  dsh;
  logic              tx, ty;
  logic [SW-1:0]     rx_q, ry_q, dm_q;
  logic [QB-1:0]     qx_q, qy_q, qx_d, qy_d;
  ppt_flags_t        f_q;

  assign ready_o = !v_q || ready_i;

  // shifted divisor; remainder stays below twice this value
  assign dsh = (SW+QB)'(dm_i) << BIT;
  assign tx  = {{QB{1'b0}}, rx_i} >= dsh;
  assign ty  = {{QB{1'b0}}, ry_i} >= dsh;

  always_comb begin
    qx_d      = qx_i;
    qy_d      = qy_i;
    qx_d[BIT] = tx;
    qy_d[BIT] = ty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rx_q <= tx ? rx_i - dsh[SW-1:0] : rx_i;
      ry_q <= ty ? ry_i - dsh[SW-1:0] : ry_i;
      dm_q <= dm_i;
      qx_q <= qx_d;
      qy_q <= qy_d;
      f_q  <= flags_i;
    end
  end

  assign valid_o = v_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign dm_o    = dm_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign flags_o = f_q;
endmodule

### rtl/core/projective_point_transform.sv
// top level: registers, product front end, divider cell row, output stage
// Maps one signed pixel point (x, y) through a 3x3 projective matrix of
// Q16.16 coefficients and returns the truncated, saturated quotients.
// One point is accepted per cycle while in_stall_o is low, and results
// leave in order. The pipeline is one product stage, one sum stage, a
// row of COORD_BITS+1 division cells that each settle one quotient bit
// for both coordinates, and the output register. Every stage holds its
// item while the stage below it is full, so idle slots close up.
// The matrix is written over the APB-style port at byte address 8*i and is
// only to be changed while no transaction is in flight.
module projective_point_transform import ppt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [5:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  x_in_i,
  input  logic signed [COORD_BITS-1:0]  y_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  x_out_o,
  output logic signed [COORD_BITS-1:0]  y_out_o,
  output logic                          zero_denominator_o,
  output logic                          saturated_o
);
  localparam int SW = COORD_BITS + 34;
  localparam int QB = COORD_BITS + 1;
  localparam logic [QB-1:0] HALF = QB'(1) << (COORD_BITS - 1);

  // configuration registers
  logic [63:0]          pair_q [4];
  logic [COEF_BITS-1:0] last_q;
  logic                 mode_q;
  logic                 wr_en;
  ppt_reg_e             wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = ppt_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q[0] <= 64'(COEF_ONE);
      pair_q[1] <= '0;
      pair_q[2] <= 64'(COEF_ONE);
      pair_q[3] <= '0;
      last_q    <= COEF_ONE;
      mode_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_PAIR_0_1: pair_q[0] <= pwdata;
        REG_PAIR_2_3: pair_q[1] <= pwdata;
        REG_PAIR_4_5: pair_q[2] <= pwdata;
        REG_PAIR_6_7: pair_q[3] <= pwdata;
        REG_LAST:     last_q    <= pwdata[COEF_BITS-1:0];
        REG_MODE:     mode_q    <= pwdata[0];
        default:      ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (ppt_reg_e'(paddr[5:3]))
      REG_PAIR_0_1: prdata = pair_q[0];
      REG_PAIR_2_3: prdata = pair_q[1];
      REG_PAIR_4_5: prdata = pair_q[2];
      REG_PAIR_6_7: prdata = pair_q[3];
      REG_LAST:     prdata = 64'(last_q);
      REG_MODE:     prdata = 64'(mode_q);
      default:      prdata = '0;
    endcase
  end

  // unpack the nine coefficients
  logic signed [COEF_BITS-1:0] e [9];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      e[k] = pair_q[k/2][32*(k%2) +: COEF_BITS];
    end
    e[8] = last_q;
  end

  // pick row or column use; slots are x numerator, y numerator, denominator
  logic signed [COEF_BITS-1:0] cx [3];
  logic signed [COEF_BITS-1:0] cy [3];
  logic signed [COEF_BITS-1:0] cc [3];
  always_comb begin
    if (mode_q) begin
      cx[0] = e[0]; cy[0] = e[3]; cc[0] = e[6];
      cx[1] = e[1]; cy[1] = e[4]; cc[1] = e[7];
      cx[2] = e[2]; cy[2] = e[5]; cc[2] = e[8];
    end else begin
      cx[0] = e[0]; cy[0] = e[1]; cc[0] = e[2];
      cx[1] = e[3]; cy[1] = e[4]; cc[1] = e[5];
      cx[2] = e[6]; cy[2] = e[7]; cc[2] = e[8];
    end
  end

  // chain wiring: index 0 is the front end output, index QB the row output
  logic             cv   [QB+1];
  logic             crdy [QB+1];
  logic [SW-1:0]    crx  [QB+1];
  logic [SW-1:0]    cry  [QB+1];
  logic [SW-1:0]    cdm  [QB+1];
  logic [QB-1:0]    cqx  [QB+1];
  logic [QB-1:0]    cqy  [QB+1];
  ppt_flags_t       cf   [QB+1];
  logic             mac_rdy;

  assign in_stall_o = !mac_rdy;
  assign cqx[0]     = '0;
  assign cqy[0]     = '0;

  ppt_mac #(.COORD_BITS(COORD_BITS)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (mac_rdy),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .cx_i    (cx),
    .cy_i    (cy),
    .cc_i    (cc),
    .valid_o (cv[0]),
    .ready_i (crdy[0]),
    .xm_o    (crx[0]),
    .ym_o    (cry[0]),
    .dm_o    (cdm[0]),
    .flags_o (cf[0])
  );

  // cell j settles quotient bit QB-1-j, most significant first
  for (genvar j = 0; j < QB; j++) begin : g_cell
    ppt_div_cell #(.COORD_BITS(COORD_BITS), .BIT(QB-1-j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[j]),
      .ready_o (crdy[j]),
      .rx_i    (crx[j]),
      .ry_i    (cry[j]),
      .dm_i    (cdm[j]),
      .qx_i    (cqx[j]),
      .qy_i    (cqy[j]),
      .flags_i (cf[j]),
      .valid_o (cv[j+1]),
      .ready_i (crdy[j+1]),
      .rx_o    (crx[j+1]),
      .ry_o    (cry[j+1]),
      .dm_o    (cdm[j+1]),
      .qx_o    (cqx[j+1]),
      .qy_o    (cqy[j+1]),
      .flags_o (cf[j+1])
    );
  end

  // sign, saturation and zero-denominator handling
  ppt_flags_t                 fl;
  logic                       xneg, yneg, xsat, ysat;
  logic [QB-1:0]              qx, qy;
  logic signed [COORD_BITS-1:0] xr, yr;
  logic                       unused_rem;

  assign fl = cf[QB];
  assign qx = cqx[QB];
  assign qy = cqy[QB];
  // remainders are not needed past the last cell
  assign unused_rem = ^{crx[QB], cry[QB], cdm[QB]};

  always_comb begin
    xneg = (fl.xn != fl.dn) && (fl.xo || qx != '0);
    yneg = (fl.yn != fl.dn) && (fl.yo || qy != '0);
    xsat = fl.xo || (xneg ? (qx > HALF) : (qx > HALF - QB'(1)));
    ysat = fl.yo || (yneg ? (qy > HALF) : (qy > HALF - QB'(1)));
    if (xsat) begin
      xr = xneg ? COORD_BITS'(HALF) : COORD_BITS'(HALF - QB'(1));
    end else begin
      xr = xneg ? COORD_BITS'(~qx + QB'(1)) : COORD_BITS'(qx);
    end
    if (ysat) begin
      yr = yneg ? COORD_BITS'(HALF) : COORD_BITS'(HALF - QB'(1));
    end else begin
      yr = yneg ? COORD_BITS'(~qy + QB'(1)) : COORD_BITS'(qy);
    end
  end

  // output register
  logic                         ov_q;
  logic signed [COORD_BITS-1:0] xo_q, yo_q;
  logic                         zo_q, so_q;

  assign crdy[QB] = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (crdy[QB]) begin
      ov_q <= cv[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (crdy[QB] && cv[QB]) begin
      xo_q <= fl.dz ? '0 : xr;
      yo_q <= fl.dz ? '0 : yr;
      zo_q <= fl.dz;
      so_q <= !fl.dz && (xsat || ysat) && !unused_rem | (!fl.dz && (xsat || ysat));
    end
  end

  assign out_valid_o        = ov_q;
  assign x_out_o            = xo_q;
  assign y_out_o            = yo_q;
  assign zero_denominator_o = zo_q;
  assign saturated_o        = so_q;
endmodule

### rtl/core/ppt_checker.sv
// port-level checker for the projective point transform, bound to the top
`include "assert_macros.svh"
module ppt_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [COORD_BITS-1:0]  x_out_o,
  input logic signed [COORD_BITS-1:0]  y_out_o,
  input logic                          zero_denominator_o,
  input logic                          saturated_o
);
  `PPT_ASSERT(a_zero_den_out, out_valid_o && zero_denominator_o |-> x_out_o == '0 && y_out_o == '0, "zero denominator with nonzero coordinates")
  `PPT_NEVER(a_flags_excl, out_valid_o && zero_denominator_o && saturated_o, "zero denominator and saturation together")
  `PPT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `PPT_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(x_out_o) && $stable(y_out_o), "stalled result changed")
  `PPT_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i, "stalled input transaction withdrawn")
endmodule

bind projective_point_transform ppt_checker #(.COORD_BITS(COORD_BITS)) u_ppt_checker (.*);
